>>> rtl/core/rus_pkg.sv
package rus_pkg;

    localparam int MAX_RECTS_DEF  = 256;
    localparam int COORD_BITS_DEF = 16;
    localparam int RAND_BITS      = 48;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_PICK   = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;
    localparam logic [1:0] ST_DEGENERATE = 2'd3;

    typedef struct packed {
        logic load;
        logic clear;
        logic append_start;
        logic pick_start;
        logic resp_zero;
        logic [1:0] resp_status;
    } rus_cmd_t;

    typedef struct packed {
        logic full;
        logic degenerate;
        logic empty;
        logic busy;
        logic done;
    } rus_sts_t;

endpackage

>>> rtl/core/rect_union_point_sampler_core.sv
// channel | handshake          | payload
// s_      | s_valid / s_ready  | command, left_x, bottom_y, right_x, top_y, random_word
// m_      | m_valid / m_ready  | point_x, point_y, status
// m_valid follows done, raised at accept for clear, unknown and flagged items,
// after P_APRD, P_APWT and P_APWR for an append; a pick runs P_APRD, P_APWT, P_TOT,
// the 48-step modulo, two states per search step, P_FIN, P_FINW, the 43-step division.
// One item at a time; s_ready is low from accept until the result is taken.
// Reset: synchronous active-low aresetn empties the table, no clearing pass.
module rect_union_point_sampler_core #(
    parameter int MAX_RECTS  = rus_pkg::MAX_RECTS_DEF,
    parameter int COORD_BITS = rus_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic signed [COORD_BITS-1:0]  s_left_x,
    input  logic signed [COORD_BITS-1:0]  s_bottom_y,
    input  logic signed [COORD_BITS-1:0]  s_right_x,
    input  logic signed [COORD_BITS-1:0]  s_top_y,
    input  logic [rus_pkg::RAND_BITS-1:0] s_random_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS-1:0]  m_point_x,
    output logic signed [COORD_BITS-1:0]  m_point_y,
    output logic [1:0]                    m_status
);

    rus_pkg::rus_cmd_t cmd;
    rus_pkg::rus_sts_t sts;

    rus_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .sts(sts)
    );

    rus_datapath #(.MAX_RECTS(MAX_RECTS), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_lx(s_left_x), .in_by(s_bottom_y), .in_rx(s_right_x), .in_ty(s_top_y),
        .in_rand(s_random_word), .point_x(m_point_x), .point_y(m_point_y),
        .status(m_status)
    );

endmodule

>>> rtl/core/rus_ram.sv
module rus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/rus_datapath.sv
module rus_datapath #(
    parameter int MAX_RECTS  = rus_pkg::MAX_RECTS_DEF,
    parameter int COORD_BITS = rus_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rus_pkg::rus_cmd_t            cmd,
    output rus_pkg::rus_sts_t            sts,
    input  logic signed [COORD_BITS-1:0] in_lx,
    input  logic signed [COORD_BITS-1:0] in_by,
    input  logic signed [COORD_BITS-1:0] in_rx,
    input  logic signed [COORD_BITS-1:0] in_ty,
    input  logic [rus_pkg::RAND_BITS-1:0] in_rand,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic [1:0]                   status
);

    localparam int AW  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW  = $clog2(MAX_RECTS + 1);
    localparam int DW  = COORD_BITS + 1;
    localparam int AR  = 2 * DW;
    localparam int PW  = AR + CW;
    localparam int RB  = rus_pkg::RAND_BITS;
    localparam int MW  = (PW > RB) ? PW : RB;
    localparam int RW  = 4 * COORD_BITS;
    localparam int MCW = $clog2(MW + 1);
    localparam int DCW = $clog2(PW + 1);

    typedef enum logic [10:0] {
        P_IDLE  = 11'b00000000001,
        P_APRD  = 11'b00000000010,
        P_APWT  = 11'b00000000100,
        P_APWR  = 11'b00000001000,
        P_TOT   = 11'b00000010000,
        P_MOD   = 11'b00000100000,
        P_SRCH  = 11'b00001000000,
        P_SRWT  = 11'b00010000000,
        P_FIN   = 11'b00100000000,
        P_FINW  = 11'b01000000000,
        P_DIV   = 11'b10000000000
    } pstate_t;

    pstate_t state_reg, state_next;
    logic [CW-1:0] count_reg;

    logic signed [COORD_BITS-1:0] lx_reg, by_reg, rx_reg, ty_reg;
    logic [RB-1:0] rand_reg;
    logic [DW-1:0] w_reg, h_reg;
    logic [AR-1:0] area_reg;
    logic [PW-1:0] total_reg;
    logic [MW-1:0] rem_reg;
    logic [MCW-1:0] bit_reg;
    logic [PW-1:0] idx_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [CW-1:0] mid_reg;
    logic [PW-1:0] off_reg;
    logic [PW-1:0] drem_reg;
    logic [PW-1:0] dq_reg;
    logic [DCW-1:0] dbit_reg;
    logic [DW-1:0] dw_reg;
    logic signed [COORD_BITS-1:0] blx_reg, bby_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic [1:0] st_reg;
    logic done_reg;
    logic rand_sel_reg;
    logic srch_rd_reg;

    logic          p_we;
    logic [AW-1:0] p_waddr, p_raddr, r_raddr;
    logic [PW-1:0] p_wdata, p_rdata;
    logic [PW-1:0] p_rdata_prev;
    logic [RW-1:0] r_rdata;

    rus_ram #(.WIDTH(PW), .DEPTH(MAX_RECTS)) u_prefix (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    rus_ram #(.WIDTH(RW), .DEPTH(MAX_RECTS)) u_rect (
        .aclk(aclk), .we(p_we), .waddr(p_waddr),
        .wdata({lx_reg, by_reg, rx_reg, ty_reg}),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] mid_c;
    logic [MW:0]   mod_trial;
    logic [PW:0]   div_trial;
    logic [CW-1:0] lo_m1;

    assign cnt_m1 = count_reg - CW'(1);
    assign mid_c  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1  = lo_reg - CW'(1);
    assign mod_trial = {rem_reg, rand_reg[RB-1]} - {1'b0, MW'(total_reg)};
    assign div_trial = {drem_reg, off_reg[PW-1]} - {1'b0, PW'(dw_reg)};

    assign p_rdata_prev = (count_reg == '0) ? '0 : p_rdata;

    assign p_we    = (state_reg == P_APWR);
    assign p_waddr = AW'(count_reg);
    assign p_wdata = p_rdata_prev + PW'(area_reg);

    always_comb begin
        p_raddr = AW'(cnt_m1);
        r_raddr = AW'(lo_reg);
        case (state_reg)
            P_SRCH:  p_raddr = AW'(mid_c);
            P_FIN:   p_raddr = AW'(lo_m1);
            default: p_raddr = AW'(cnt_m1);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            P_IDLE: begin
                if (cmd.append_start) begin
                    state_next = P_APRD;
                end else if (cmd.pick_start) begin
                    state_next = P_APRD;
                end
            end
            P_APRD:  state_next = P_APWT;
            P_APWT:  state_next = rand_sel_reg ? P_TOT : P_APWR;
            P_APWR:  state_next = P_IDLE;
            P_TOT:   state_next = (p_rdata == '0) ? P_IDLE : P_MOD;
            P_MOD:   state_next = (bit_reg == MCW'(RB - 1)) ? P_SRCH : P_MOD;
            P_SRCH:  state_next = (lo_reg >= hi_reg) ? P_FIN : P_SRWT;
            P_SRWT:  state_next = P_SRCH;
            P_FIN:   state_next = P_FINW;
            P_FINW:  state_next = P_DIV;
            P_DIV:   state_next = (dbit_reg == DCW'(PW - 1)) ? P_IDLE : P_DIV;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            st_reg    <= rus_pkg::ST_OK;
            px_reg    <= '0;
            py_reg    <= '0;
            rand_sel_reg <= 1'b0;
            srch_rd_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cmd.load) begin
                lx_reg   <= in_lx;
                by_reg   <= in_by;
                rx_reg   <= in_rx;
                ty_reg   <= in_ty;
                rand_reg <= in_rand;
                w_reg <= DW'($signed({in_rx[COORD_BITS-1], in_rx})
                       - $signed({in_lx[COORD_BITS-1], in_lx}) + 1);
                h_reg <= DW'($signed({in_ty[COORD_BITS-1], in_ty})
                       - $signed({in_by[COORD_BITS-1], in_by}) + 1);
            end
            if (cmd.clear) begin
                count_reg <= '0;
            end
            if (cmd.resp_zero) begin
                px_reg   <= '0;
                py_reg   <= '0;
                st_reg   <= cmd.resp_status;
                done_reg <= 1'b1;
            end
            case (state_reg)
                P_IDLE: rand_sel_reg <= cmd.pick_start;
                P_APRD: area_reg <= AR'(w_reg) * AR'(h_reg);
                P_APWR: begin
                    count_reg <= count_reg + CW'(1);
                    px_reg <= '0;
                    py_reg <= '0;
                    st_reg <= rus_pkg::ST_OK;
                    done_reg <= 1'b1;
                end
                P_TOT: begin
                    total_reg <= p_rdata;
                    rem_reg   <= '0;
                    bit_reg   <= '0;
                    if (p_rdata == '0) begin
                        px_reg <= '0;
                        py_reg <= '0;
                        st_reg <= rus_pkg::ST_EMPTY;
                        done_reg <= 1'b1;
                    end
                end
                P_MOD: begin
                    if (!mod_trial[MW]) begin
                        rem_reg <= mod_trial[MW-1:0];
                    end else begin
                        rem_reg <= {rem_reg[MW-2:0], rand_reg[RB-1]};
                    end
                    rand_reg <= {rand_reg[RB-2:0], 1'b0};
                    bit_reg  <= bit_reg + MCW'(1);
                    if (bit_reg == MCW'(RB - 1)) begin
                        lo_reg <= '0;
                        hi_reg <= cnt_m1;
                        srch_rd_reg <= 1'b0;
                    end
                end
                P_SRCH: begin
                    if (lo_reg == '0 && bit_reg == MCW'(RB)) begin
                        bit_reg <= '0;
                    end
                    if (!srch_rd_reg) begin
                        idx_reg <= PW'(rem_reg) + PW'(1);
                    end
                    srch_rd_reg <= 1'b1;
                    mid_reg <= mid_c;
                end
                P_SRWT: begin
                    if (p_rdata >= idx_reg) begin
                        hi_reg <= mid_reg;
                    end else begin
                        lo_reg <= mid_reg + CW'(1);
                    end
                end
                P_FIN: ;
                P_FINW: begin
                    off_reg  <= idx_reg - ((lo_reg == '0) ? PW'(1) : p_rdata + PW'(1));
                    blx_reg  <= r_rdata[RW-1 -: COORD_BITS];
                    bby_reg  <= r_rdata[RW-COORD_BITS-1 -: COORD_BITS];
                    dw_reg   <= DW'($signed({r_rdata[2*COORD_BITS-1],
                                 r_rdata[2*COORD_BITS-1 -: COORD_BITS]})
                              - $signed({r_rdata[RW-1], r_rdata[RW-1 -: COORD_BITS]}) + 1);
                    drem_reg <= '0;
                    dq_reg   <= '0;
                    dbit_reg <= '0;
                end
                P_DIV: begin
                    if (!div_trial[PW]) begin
                        drem_reg <= div_trial[PW-1:0];
                        dq_reg   <= {dq_reg[PW-2:0], 1'b1};
                    end else begin
                        drem_reg <= {drem_reg[PW-2:0], off_reg[PW-1]};
                        dq_reg   <= {dq_reg[PW-2:0], 1'b0};
                    end
                    off_reg  <= {off_reg[PW-2:0], 1'b0};
                    dbit_reg <= dbit_reg + DCW'(1);
                    if (dbit_reg == DCW'(PW - 1)) begin
                        px_reg <= blx_reg + COORD_BITS'(!div_trial[PW] ?
                                  div_trial[PW-1:0] : {drem_reg[PW-2:0], off_reg[PW-1]});
                        py_reg <= bby_reg + COORD_BITS'({dq_reg[PW-2:0], !div_trial[PW]});
                        st_reg <= rus_pkg::ST_OK;
                        done_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign sts.full       = (count_reg >= CW'(MAX_RECTS));
    assign sts.degenerate = (in_rx < in_lx) || (in_ty < in_by);
    assign sts.empty      = (count_reg == '0);
    assign sts.busy       = (state_reg != P_IDLE);
    assign sts.done       = done_reg;

    assign point_x = px_reg;
    assign point_y = py_reg;
    assign status  = st_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_RECTS)) else $error("count overflow");
    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        p_we |-> count_reg < CW'(MAX_RECTS)) else $error("write into full table");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> state_reg == P_IDLE) else $error("done while busy");
`endif

endmodule

>>> rtl/core/rus_ctrl.sv
module rus_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    output logic              m_valid,
    input  logic              m_ready,
    output rus_pkg::rus_cmd_t cmd,
    input  rus_pkg::rus_sts_t sts
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_WORK = 3'b010,
        C_OUT  = 3'b100
    } cstate_t;

    cstate_t state_reg, state_next;
    logic    acc;

    assign s_ready = (state_reg == C_IDLE);
    assign m_valid = (state_reg == C_OUT);
    assign acc     = s_valid && s_ready;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            C_IDLE: begin
                if (acc) begin
                    cmd.load = 1'b1;
                    state_next = C_WORK;
                    case (s_command)
                        rus_pkg::CMD_CLEAR: begin
                            cmd.clear = 1'b1;
                            cmd.resp_zero = 1'b1;
                            cmd.resp_status = rus_pkg::ST_OK;
                        end
                        rus_pkg::CMD_APPEND: begin
                            if (sts.full) begin
                                cmd.resp_zero = 1'b1;
                                cmd.resp_status = rus_pkg::ST_FULL;
                            end else if (sts.degenerate) begin
                                cmd.resp_zero = 1'b1;
                                cmd.resp_status = rus_pkg::ST_DEGENERATE;
                            end else begin
                                cmd.append_start = 1'b1;
                            end
                        end
                        rus_pkg::CMD_PICK: begin
                            if (sts.empty) begin
                                cmd.resp_zero = 1'b1;
                                cmd.resp_status = rus_pkg::ST_EMPTY;
                            end else begin
                                cmd.pick_start = 1'b1;
                            end
                        end
                        default: begin
                            cmd.resp_zero = 1'b1;
                            cmd.resp_status = rus_pkg::ST_OK;
                        end
                    endcase
                end
            end
            C_WORK:  if (sts.done) state_next = C_OUT;
            C_OUT:   if (m_ready) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != C_IDLE) |-> !s_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_done_work: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.done |-> (state_reg == C_WORK)) else $error("stray done");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_IDLE) |-> !sts.busy) else $error("datapath busy while idle");
`endif

endmodule
